/* sv/pid_axis_motor_drive_core_macros.svh */
// Assertion macros shared by the motor drive core.
`ifndef PID_AXIS_MOTOR_DRIVE_CORE_MACROS_SVH
`define PID_AXIS_MOTOR_DRIVE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PMD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PMD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pmd_pkg.sv */
// Shared constants, control word types and microprogram for the motor drive core.
`timescale 1ns / 1ps

package pmd_pkg;

    // Field widths
    localparam int ANGLE_BITS = 16;
    localparam int ERR_W      = ANGLE_BITS + 1;
    localparam int GAIN_W     = 24;
    localparam int EL_W       = 16;
    localparam int RATE_W     = 16;
    localparam int DUTY_W     = 8;
    localparam int PID_W      = 48;

    // Datapath widths
    localparam int MUL_W      = 25;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 64;
    localparam int IMAG_SPLIT = PID_W / 2;
    localparam int IPROD_W    = PID_W + GAIN_W;
    localparam int DIVD_W     = 40;
    localparam int DIV_RADIX  = 4;
    localparam int DIV_STEPS  = DIVD_W / DIV_RADIX;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [ANGLE_BITS-1:0] ANGLE_QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};
    localparam logic [ANGLE_BITS-1:0] ANGLE_HALF    = {1'b1, {(ANGLE_BITS-1){1'b0}}};

    localparam int ITERM_LIMIT_SHIFT = 60;
    localparam logic [IPROD_W-1:0] ITERM_LIMIT =
        {{(IPROD_W-1){1'b0}}, 1'b1} << ITERM_LIMIT_SHIFT;

    localparam int DUTY_CLAMP_W = 18;
    localparam logic [DUTY_CLAMP_W-1:0] DUTY_CLAMP = 18'd131072;
    localparam int SCALE_W = 7;
    localparam logic [SCALE_W-1:0] DUTY_SCALE = 7'd100;
    localparam int DUTY_FRAC     = 16;
    localparam int MANUAL_SHIFT  = 9;
    localparam logic [DUTY_W-1:0] DUTY_SAT       = 8'd255;
    localparam logic [DUTY_W-1:0] TRACK_DUTY_MAX = 8'd200;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_W;
    localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT   = 3'd4;

    // Datapath operations
    typedef logic [3:0] t_op;
    localparam t_op OP_NOP       = 4'd0;
    localparam t_op OP_PREP      = 4'd1;
    localparam t_op OP_INTEG     = 4'd2;
    localparam t_op OP_ACC_LOAD  = 4'd3;
    localparam t_op OP_DIV_START = 4'd4;
    localparam t_op OP_IHI       = 4'd5;
    localparam t_op OP_ILO       = 4'd6;
    localparam t_op OP_ILIM      = 4'd7;
    localparam t_op OP_IADD      = 4'd8;
    localparam t_op OP_DSUB      = 4'd9;
    localparam t_op OP_SAT       = 4'd10;
    localparam t_op OP_OUT_T     = 4'd11;
    localparam t_op OP_OUT_M     = 4'd12;

    // Multiplier operand selection
    typedef logic [2:0] t_mul;
    localparam t_mul MUL_NONE   = 3'd0;
    localparam t_mul MUL_ERR_EL = 3'd1;
    localparam t_mul MUL_KP_ERR = 3'd2;
    localparam t_mul MUL_KD_DM  = 3'd3;
    localparam t_mul MUL_KI_HI  = 3'd4;
    localparam t_mul MUL_KI_LO  = 3'd5;

    // Hold conditions
    typedef logic [1:0] t_hold;
    localparam t_hold WAIT_NONE = 2'd0;
    localparam t_hold WAIT_DIV  = 2'd1;
    localparam t_hold WAIT_OUT  = 2'd2;

    // Branch kinds
    typedef logic [1:0] t_br;
    localparam t_br BR_NEXT   = 2'd0;
    localparam t_br BR_MANUAL = 2'd1;
    localparam t_br BR_END    = 2'd2;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc UPC_PREP   = 4'd0;
    localparam t_pc UPC_MUL_EE = 4'd1;
    localparam t_pc UPC_INTEG  = 4'd2;
    localparam t_pc UPC_PTERM  = 4'd3;
    localparam t_pc UPC_DSTART = 4'd4;
    localparam t_pc UPC_IHI    = 4'd5;
    localparam t_pc UPC_ILO    = 4'd6;
    localparam t_pc UPC_ILIM   = 4'd7;
    localparam t_pc UPC_IADD   = 4'd8;
    localparam t_pc UPC_DWAIT  = 4'd9;
    localparam t_pc UPC_DSUB   = 4'd10;
    localparam t_pc UPC_SAT    = 4'd11;
    localparam t_pc UPC_OUT_T  = 4'd12;
    localparam t_pc UPC_OUT_M  = 4'd13;

    typedef struct packed {
        t_op   op;
        t_mul  mul;
        t_hold hold;
        t_br   br;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic load;
        t_op  op;
        t_mul mul;
    } t_ctrl;

    typedef struct packed {
        logic manual;
        logic div_busy;
        logic out_full;
    } t_status;

    // Microprogram. The multiplier result of one step is used by the next.
    function automatic t_uword f_urom(input t_pc pc);
        t_uword w;
        unique case (pc)
            UPC_PREP:   w = '{OP_PREP,      MUL_NONE,   WAIT_NONE, BR_MANUAL, UPC_OUT_M};
            UPC_MUL_EE: w = '{OP_NOP,       MUL_ERR_EL, WAIT_NONE, BR_NEXT,   UPC_PREP};
            UPC_INTEG:  w = '{OP_INTEG,     MUL_KP_ERR, WAIT_NONE, BR_NEXT,   UPC_PREP};
            UPC_PTERM:  w = '{OP_ACC_LOAD,  MUL_KD_DM,  WAIT_NONE, BR_NEXT,   UPC_PREP};
            UPC_DSTART: w = '{OP_DIV_START, MUL_KI_HI,  WAIT_NONE, BR_NEXT,   UPC_PREP};
            UPC_IHI:    w = '{OP_IHI,       MUL_KI_LO,  WAIT_NONE, BR_NEXT,   UPC_PREP};
            UPC_ILO:    w = '{OP_ILO,       MUL_NONE,   WAIT_NONE, BR_NEXT,   UPC_PREP};
            UPC_ILIM:   w = '{OP_ILIM,      MUL_NONE,   WAIT_NONE, BR_NEXT,   UPC_PREP};
            UPC_IADD:   w = '{OP_IADD,      MUL_NONE,   WAIT_NONE, BR_NEXT,   UPC_PREP};
            UPC_DWAIT:  w = '{OP_NOP,       MUL_NONE,   WAIT_DIV,  BR_NEXT,   UPC_PREP};
            UPC_DSUB:   w = '{OP_DSUB,      MUL_NONE,   WAIT_NONE, BR_NEXT,   UPC_PREP};
            UPC_SAT:    w = '{OP_SAT,       MUL_NONE,   WAIT_NONE, BR_NEXT,   UPC_PREP};
            UPC_OUT_T:  w = '{OP_OUT_T,     MUL_NONE,   WAIT_OUT,  BR_END,    UPC_PREP};
            UPC_OUT_M:  w = '{OP_OUT_M,     MUL_NONE,   WAIT_OUT,  BR_END,    UPC_PREP};
            default:    w = '{OP_NOP,       MUL_NONE,   WAIT_NONE, BR_END,    UPC_PREP};
        endcase
        return w;
    endfunction

endpackage

/* sv/pmd_div.sv */
// Iterative unsigned divider, four quotient bits per cycle.
`timescale 1ns / 1ps

module pmd_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pmd_pkg::DIVD_W-1:0] i_dividend,
    input  logic [pmd_pkg::EL_W-1:0]   i_divisor,
    output logic                       o_busy,
    output logic [pmd_pkg::DIVD_W-1:0] o_quotient
);
    import pmd_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [EL_W-1:0]      r_rem;
    logic [EL_W-1:0]      r_dvs;
    logic [DIVD_W-1:0]    r_quo;
    logic [EL_W-1:0]      n_rem;
    logic [DIVD_W-1:0]    n_quo;

    // The dividend shifts out of the top of r_quo while quotient bits enter at the bottom.
    always_comb begin
        logic [EL_W:0]     v_rem;
        logic [DIVD_W-1:0] v_quo;
        v_rem = {1'b0, r_rem};
        v_quo = r_quo;
        for (int i = 0; i < DIV_RADIX; i++) begin
            v_rem = {v_rem[EL_W-1:0], v_quo[DIVD_W-1]};
            v_quo = {v_quo[DIVD_W-2:0], 1'b0};
            if (v_rem >= {1'b0, r_dvs}) begin
                v_rem    = v_rem - {1'b0, r_dvs};
                v_quo[0] = 1'b1;
            end
        end
        n_rem = v_rem[EL_W-1:0];
        n_quo = v_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

/* sv/pmd_dpath.sv */
// Datapath of the motor drive core: configuration, state, shared multiplier and result register.
`timescale 1ns / 1ps

module pmd_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pmd_pkg::t_ctrl                 i_ctrl,
    output pmd_pkg::t_status               o_status,
    input  logic                           i_cfg_we,
    input  logic [pmd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [pmd_pkg::ANGLE_BITS-1:0] i_target_angle,
    input  logic [pmd_pkg::ANGLE_BITS-1:0] i_measured_angle,
    input  logic [pmd_pkg::EL_W-1:0]       i_elapsed_us,
    input  logic signed [pmd_pkg::RATE_W-1:0] i_manual_rate,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [pmd_pkg::DUTY_W-1:0]     o_lead_one_duty,
    output logic [pmd_pkg::DUTY_W-1:0]     o_lead_two_duty,
    output logic                           o_forward,
    output logic signed [pmd_pkg::PID_W-1:0] o_pid_value
);
    import pmd_pkg::*;

    localparam int MQ_W = RATE_W + SCALE_W - MANUAL_SHIFT;

    // Configuration and state
    logic [GAIN_W-1:0]        r_kp;
    logic [GAIN_W-1:0]        r_ki;
    logic [GAIN_W-1:0]        r_kd;
    logic                     r_track;
    logic                     r_alt;
    logic [ANGLE_BITS-1:0]    r_last;
    logic signed [PID_W-1:0]  r_integ;

    // Item and working registers
    logic [ANGLE_BITS-1:0]    r_tgt;
    logic [ANGLE_BITS-1:0]    r_meas;
    logic [EL_W-1:0]          r_el;
    logic signed [RATE_W-1:0] r_rate;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [ERR_W-1:0]  r_dmeas;
    logic                     r_fwd;
    logic [PID_W-1:0]         r_imag;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [IPROD_W-1:0]       r_iprod;
    logic                     r_dneg;
    logic signed [PID_W-1:0]  r_pid;

    // Result register
    logic                     r_out_valid;
    logic [DUTY_W-1:0]        r_lead_one;
    logic [DUTY_W-1:0]        r_lead_two;
    logic                     r_out_fwd;
    logic signed [PID_W-1:0]  r_out_pid;

    logic [ANGLE_BITS-1:0]    w_tgt_c;
    logic [ANGLE_BITS-1:0]    w_adiff;
    logic signed [ERR_W-1:0]  w_err;
    logic signed [ERR_W-1:0]  w_dmeas;
    logic                     w_fwd;
    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_isum;
    logic [PROD_W-1:0]        w_prod_mag;
    logic [ACC_W-1:0]         w_iterm;
    logic [ACC_W-1:0]         w_dterm;
    logic                     w_div_busy;
    logic [DIVD_W-1:0]        w_quo;
    logic [PID_W-1:0]         w_pid_mag;
    logic [DUTY_CLAMP_W-1:0]  w_clamp;
    logic [DUTY_CLAMP_W+SCALE_W-1:0] w_tprod;
    logic [DUTY_W-1:0]        w_tduty;
    logic [RATE_W-1:0]        w_rate_mag;
    logic [RATE_W+SCALE_W-1:0] w_mprod;
    logic [MQ_W-1:0]          w_mq;
    logic [DUTY_W-1:0]        w_mduty;

    function automatic logic signed [PID_W-1:0] f_sat_pid(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-PID_W:0] v_top;
        logic signed [PID_W-1:0] v_res;
        v_top = v[ACC_W-1:PID_W-1];
        if (v_top == '0 || v_top == '1) begin
            v_res = v[PID_W-1:0];
        end else if (v[ACC_W-1]) begin
            v_res = {1'b1, {(PID_W-1){1'b0}}};
        end else begin
            v_res = {1'b0, {(PID_W-1){1'b1}}};
        end
        return v_res;
    endfunction

    // On the altitude axis the target arrives as a zenith distance.
    assign w_tgt_c = r_alt ? ((r_tgt <= ANGLE_QUARTER) ? ANGLE_QUARTER - r_tgt : '0) : r_tgt;
    assign w_err   = $signed({1'b0, w_tgt_c}) - $signed({1'b0, r_meas});
    assign w_dmeas = $signed({1'b0, r_meas}) - $signed({1'b0, r_last});
    assign w_adiff = w_tgt_c - r_meas;
    assign w_fwd   = (w_adiff <= ANGLE_HALF);

    always_comb begin
        unique case (i_ctrl.mul)
            MUL_ERR_EL: begin
                w_mul_a = {{(MUL_W-ERR_W){r_err[ERR_W-1]}}, r_err};
                w_mul_b = {{(MUL_W-EL_W){1'b0}}, r_el};
            end
            MUL_KP_ERR: begin
                w_mul_a = {{(MUL_W-GAIN_W){1'b0}}, r_kp};
                w_mul_b = {{(MUL_W-ERR_W){r_err[ERR_W-1]}}, r_err};
            end
            MUL_KD_DM: begin
                w_mul_a = {{(MUL_W-GAIN_W){1'b0}}, r_kd};
                w_mul_b = {{(MUL_W-ERR_W){r_dmeas[ERR_W-1]}}, r_dmeas};
            end
            MUL_KI_HI: begin
                w_mul_a = {{(MUL_W-GAIN_W){1'b0}}, r_ki};
                w_mul_b = {{(MUL_W-(PID_W-IMAG_SPLIT)){1'b0}}, r_imag[PID_W-1:IMAG_SPLIT]};
            end
            MUL_KI_LO: begin
                w_mul_a = {{(MUL_W-GAIN_W){1'b0}}, r_ki};
                w_mul_b = {{(MUL_W-IMAG_SPLIT){1'b0}}, r_imag[IMAG_SPLIT-1:0]};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign w_isum = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod}
                  + {{(ACC_W-PID_W){r_integ[PID_W-1]}}, r_integ};
    assign w_prod_mag = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign w_iterm    = r_iprod[ACC_W-1:0];
    assign w_dterm    = {{(ACC_W-DIVD_W){1'b0}}, w_quo};

    // Tracking duty: |pid| clamped to 2.0, times 100, fraction dropped.
    assign w_pid_mag = r_pid[PID_W-1] ? PID_W'(-r_pid) : PID_W'(r_pid);
    assign w_clamp   = (w_pid_mag > {{(PID_W-DUTY_CLAMP_W){1'b0}}, DUTY_CLAMP})
                     ? DUTY_CLAMP : w_pid_mag[DUTY_CLAMP_W-1:0];
    assign w_tprod   = w_clamp * DUTY_SCALE;
    assign w_tduty   = w_tprod[DUTY_FRAC+DUTY_W-1:DUTY_FRAC];

    // Manual duty: |rate| * 100 / 512, saturated.
    assign w_rate_mag = r_rate[RATE_W-1] ? RATE_W'(-r_rate) : RATE_W'(r_rate);
    assign w_mprod    = w_rate_mag * DUTY_SCALE;
    assign w_mq       = w_mprod[RATE_W+SCALE_W-1:MANUAL_SHIFT];
    assign w_mduty    = (w_mq > MQ_W'(DUTY_SAT)) ? DUTY_SAT : w_mq[DUTY_W-1:0];

    pmd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctrl.op == OP_DIV_START),
        .i_dividend (w_prod_mag[DIVD_W-1:0]),
        .i_divisor  (r_el),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // Configuration, persistent state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_track     <= 1'b0;
            r_alt       <= 1'b0;
            r_last      <= '0;
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_KP:    r_kp    <= i_cfg_data[GAIN_W-1:0];
                    CFG_KI:    r_ki    <= i_cfg_data[GAIN_W-1:0];
                    CFG_KD:    r_kd    <= i_cfg_data[GAIN_W-1:0];
                    CFG_TRACK: r_track <= i_cfg_data[0];
                    CFG_ALT:   r_alt   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // The preparation step also runs in manual mode, where the state must stay put.
            if (i_ctrl.op == OP_PREP && r_track) begin
                r_last <= r_meas;
            end
            if (i_ctrl.op == OP_INTEG) begin
                r_integ <= f_sat_pid(w_isum);
            end
            if (i_ctrl.op == OP_OUT_T || i_ctrl.op == OP_OUT_M) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_imag <= r_integ[PID_W-1] ? PID_W'(-r_integ) : PID_W'(r_integ);
        if (i_ctrl.load) begin
            r_tgt  <= i_target_angle;
            r_meas <= i_measured_angle;
            r_el   <= i_elapsed_us;
            r_rate <= i_manual_rate;
        end
        unique case (i_ctrl.op)
            OP_PREP: begin
                r_err   <= w_err;
                r_dmeas <= w_dmeas;
                r_fwd   <= w_fwd;
            end
            OP_ACC_LOAD:  r_acc   <= {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            OP_DIV_START: r_dneg  <= r_prod[PROD_W-1];
            OP_IHI:       r_iprod <= {r_prod[2*GAIN_W-1:0], {GAIN_W{1'b0}}};
            OP_ILO:       r_iprod <= r_iprod + {{(IPROD_W-2*GAIN_W){1'b0}}, r_prod[2*GAIN_W-1:0]};
            OP_ILIM:      r_iprod <= (r_iprod > ITERM_LIMIT) ? ITERM_LIMIT : r_iprod;
            OP_IADD:      r_acc   <= r_integ[PID_W-1] ? r_acc - w_iterm : r_acc + w_iterm;
            OP_DSUB: begin
                // The derivative term is subtracted; zero elapsed time drops it.
                if (r_el != '0) begin
                    r_acc <= r_dneg ? r_acc + w_dterm : r_acc - w_dterm;
                end
            end
            OP_SAT:       r_pid   <= f_sat_pid(r_acc);
            OP_OUT_T: begin
                r_out_fwd  <= r_fwd;
                r_lead_one <= r_fwd ? '0 : w_tduty;
                r_lead_two <= r_fwd ? w_tduty : '0;
                r_out_pid  <= r_pid;
            end
            OP_OUT_M: begin
                r_out_fwd  <= ~r_rate[RATE_W-1];
                r_lead_one <= r_rate[RATE_W-1] ? w_mduty : '0;
                r_lead_two <= r_rate[RATE_W-1] ? '0 : w_mduty;
                r_out_pid  <= '0;
            end
            default: ;
        endcase
    end

    assign o_status.manual   = ~r_track;
    assign o_status.div_busy = w_div_busy;
    assign o_status.out_full = r_out_valid & i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_lead_one_duty = r_lead_one;
    assign o_lead_two_duty = r_lead_two;
    assign o_forward       = r_out_fwd;
    assign o_pid_value     = r_out_pid;

endmodule

/* sv/pmd_seq.sv */
// Microcode sequencer: step counter, control store and branch logic.
`timescale 1ns / 1ps

module pmd_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  pmd_pkg::t_status i_status,
    output pmd_pkg::t_ctrl   o_ctrl
);
    import pmd_pkg::*;

    logic   r_busy;
    t_pc    r_pc;
    logic   n_busy;
    t_pc    n_pc;
    t_uword w_uw;
    logic   w_held;
    logic   w_accept;

    assign w_uw     = f_urom(r_pc);
    assign w_accept = i_in_valid & ~r_busy;

    // A held step repeats without touching the datapath.
    assign w_held = r_busy
                  & (((w_uw.hold == WAIT_DIV) & i_status.div_busy)
                   | ((w_uw.hold == WAIT_OUT) & i_status.out_full));

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (w_accept) begin
                n_busy = 1'b1;
                n_pc   = UPC_PREP;
            end
        end else if (!w_held) begin
            unique case (w_uw.br)
                BR_END:    n_busy = 1'b0;
                BR_MANUAL: n_pc   = i_status.manual ? w_uw.target : PC_W'(r_pc + 1'b1);
                BR_NEXT:   n_pc   = PC_W'(r_pc + 1'b1);
                default:   n_pc   = PC_W'(r_pc + 1'b1);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= UPC_PREP;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_ctrl.load = w_accept;
    assign o_ctrl.op   = (r_busy & ~w_held) ? w_uw.op : OP_NOP;
    assign o_ctrl.mul  = r_busy ? w_uw.mul : MUL_NONE;

endmodule

/* sv/pid_axis_motor_drive_core.sv */
// Tracking request: the result comes from 13 microprogram steps, with the divider wait step
// held on the radix-16 divider; the next request is taken once the sequencer is idle again.
// Manual request: the preparation step branches to the manual output step; no request is taken while busy.
// A stalled result holds the final step, so the following request waits on the output.
// Synchronous active-low reset clears gains, mode bits, integral, last measured angle,
// the sequencer and the result valid; there is no clearing pass.
`timescale 1ns / 1ps
`include "pid_axis_motor_drive_core_macros.svh"

module pid_axis_motor_drive_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pmd_pkg::ANGLE_BITS-1:0]     i_target_angle,
    input  logic [pmd_pkg::ANGLE_BITS-1:0]     i_measured_angle,
    input  logic [pmd_pkg::EL_W-1:0]           i_elapsed_us,
    input  logic signed [pmd_pkg::RATE_W-1:0]  i_manual_rate,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [pmd_pkg::DUTY_W-1:0]         o_lead_one_duty,
    output logic [pmd_pkg::DUTY_W-1:0]         o_lead_two_duty,
    output logic                               o_forward,
    output logic signed [pmd_pkg::PID_W-1:0]   o_pid_value,
    input  logic                               i_cfg_we,
    input  logic [pmd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pmd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pmd_pkg::*;

    t_ctrl   w_ctrl;
    t_status w_status;

    pmd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl)
    );

    pmd_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (w_ctrl),
        .o_status         (w_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_target_angle   (i_target_angle),
        .i_measured_angle (i_measured_angle),
        .i_elapsed_us     (i_elapsed_us),
        .i_manual_rate    (i_manual_rate),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_lead_one_duty  (o_lead_one_duty),
        .o_lead_two_duty  (o_lead_two_duty),
        .o_forward        (o_forward),
        .o_pid_value      (o_pid_value)
    );

    `PMD_ASSERT_IMP(a_fwd_lead_one_idle, i_clk, i_rst_n, o_out_valid && o_forward, o_lead_one_duty == '0, "lead one driven while forward")
    `PMD_ASSERT_IMP(a_manual_pid_zero, i_clk, i_rst_n, o_out_valid && w_status.manual, o_pid_value == '0, "manual result with nonzero pid")
    `PMD_ASSERT_IMP(a_track_duty_max, i_clk, i_rst_n, o_out_valid && !w_status.manual, (o_lead_one_duty <= TRACK_DUTY_MAX) && (o_lead_two_duty <= TRACK_DUTY_MAX), "tracking duty above limit")
    `PMD_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, (w_ctrl.op == OP_OUT_T) || (w_ctrl.op == OP_OUT_M), !(o_out_valid && i_out_stall), "result overwritten while stalled")
    `PMD_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, w_ctrl.load, o_in_stall, "sequencer idle after accepting a request")

endmodule

/* tb/tb.sv */
// Self-checking testbench for the single-axis PID motor drive core.
`timescale 1ns / 1ps

module tb;

    localparam int ANGLE_W = pmd_pkg::ANGLE_BITS;
    localparam longint FULL_TURN = 64'sd1 << ANGLE_W;
    localparam longint ANGLE_MASK = FULL_TURN - 1;
    localparam longint HALF_TURN = FULL_TURN / 2;
    localparam longint QUARTER_TURN = FULL_TURN / 4;
    localparam longint PID_MAX = (64'sd1 <<< (pmd_pkg::PID_W - 1)) - 1;
    localparam longint PID_MIN = -PID_MAX - 1;
    localparam longint unsigned ITERM_CAP = 64'd1 << 60;
    localparam longint unsigned DUTY_CAP = 131072;
    localparam longint unsigned DUTY_PCT = 100;
    localparam longint unsigned MANUAL_DIV = 512;
    localparam longint unsigned DUTY_SAT_MAX = 255;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [pmd_pkg::ANGLE_BITS-1:0] target;
        logic [pmd_pkg::ANGLE_BITS-1:0] measured;
        logic [pmd_pkg::EL_W-1:0]       elapsed;
        logic [pmd_pkg::RATE_W-1:0]     rate;
    } t_axis_req;

    typedef struct packed {
        logic [pmd_pkg::DUTY_W-1:0] lead_one;
        logic [pmd_pkg::DUTY_W-1:0] lead_two;
        logic                       fwd;
        logic [pmd_pkg::PID_W-1:0]  pid;
    } t_drive_result;

    typedef enum {STALL_NONE, STALL_HALF, STALL_MOST, STALL_PERIODIC} t_stall_pattern;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [pmd_pkg::ANGLE_BITS-1:0] i_target_angle = '0;
    logic [pmd_pkg::ANGLE_BITS-1:0] i_measured_angle = '0;
    logic [pmd_pkg::EL_W-1:0] i_elapsed_us = '0;
    logic signed [pmd_pkg::RATE_W-1:0] i_manual_rate = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [pmd_pkg::DUTY_W-1:0] o_lead_one_duty;
    logic [pmd_pkg::DUTY_W-1:0] o_lead_two_duty;
    logic o_forward;
    logic signed [pmd_pkg::PID_W-1:0] o_pid_value;
    logic i_cfg_we = 1'b0;
    logic [pmd_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [pmd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    pid_axis_motor_drive_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_target_angle   (i_target_angle),
        .i_measured_angle (i_measured_angle),
        .i_elapsed_us     (i_elapsed_us),
        .i_manual_rate    (i_manual_rate),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_lead_one_duty  (o_lead_one_duty),
        .o_lead_two_duty  (o_lead_two_duty),
        .o_forward        (o_forward),
        .o_pid_value      (o_pid_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register mirror and controller state of the predictor.
    logic [pmd_pkg::GAIN_W-1:0] gain_p = '0;
    logic [pmd_pkg::GAIN_W-1:0] gain_i = '0;
    logic [pmd_pkg::GAIN_W-1:0] gain_d = '0;
    logic track_on = 1'b0;
    logic alt_on = 1'b0;
    longint integral_acc = 0;
    longint prev_measured = 0;

    t_axis_req request_queue[$];
    t_drive_result expected_drive_q[$];
    t_axis_req next_req;
    t_drive_result want_drive;

    int n_offered = 0;
    int n_accepted = 0;
    int n_tracking = 0;
    int n_manual = 0;
    int n_settings = 0;
    int fail_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int holds_done = 0;
    int rx_cycle = 0;
    t_stall_pattern rx_mode = STALL_NONE;
    bit fast_lane = 1'b0;

    function automatic longint clamp_pid(input longint v);
        if (v > PID_MAX) return PID_MAX;
        if (v < PID_MIN) return PID_MIN;
        return v;
    endfunction

    function automatic t_drive_result predict_drive(input t_axis_req rq);
        t_drive_result res;
        longint tgt, meas, el, rate, kp, ki, kd;
        longint err, dmeas, pterm, iterm, dterm, num, pid;
        longint unsigned mag, duty;
        tgt = longint'(rq.target);
        meas = longint'(rq.measured);
        el = longint'(rq.elapsed);
        rate = longint'($signed(rq.rate));
        kp = longint'(gain_p);
        ki = longint'(gain_i);
        kd = longint'(gain_d);
        pid = 0;
        if (track_on) begin
            // A zenith distance beyond a quarter turn points below the horizon.
            if (alt_on) tgt = (tgt <= QUARTER_TURN) ? QUARTER_TURN - tgt : 0;
            err = tgt - meas;
            dmeas = meas - prev_measured;
            prev_measured = meas;
            integral_acc = clamp_pid(integral_acc + err * el);
            pterm = kp * err;
            mag = (integral_acc < 0) ? -integral_acc : integral_acc;
            if (ki != 0 && mag > ITERM_CAP / ki) mag = ITERM_CAP;
            else mag = mag * ki;
            iterm = (integral_acc < 0) ? -$signed(mag) : $signed(mag);
            if (el == 0) begin
                dterm = 0;
            end else begin
                num = kd * dmeas;
                mag = (num < 0) ? -num : num;
                mag = mag / el;
                dterm = (num < 0) ? -$signed(mag) : $signed(mag);
            end
            pid = clamp_pid(pterm + iterm - dterm);
            mag = (pid < 0) ? -pid : pid;
            if (mag > DUTY_CAP) mag = DUTY_CAP;
            duty = (mag * DUTY_PCT) >> 16;
            res.fwd = ((tgt - meas) & ANGLE_MASK) <= HALF_TURN;
        end else begin
            mag = (rate < 0) ? -rate : rate;
            duty = mag * DUTY_PCT / MANUAL_DIV;
            if (duty > DUTY_SAT_MAX) duty = DUTY_SAT_MAX;
            res.fwd = rate >= 0;
        end
        res.lead_one = res.fwd ? '0 : duty[pmd_pkg::DUTY_W-1:0];
        res.lead_two = res.fwd ? duty[pmd_pkg::DUTY_W-1:0] : '0;
        res.pid = pid[pmd_pkg::PID_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Request acceptance and prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            expected_drive_q.push_back(predict_drive({i_target_angle, i_measured_angle,
                                                      i_elapsed_us, i_manual_rate}));
            if (track_on) n_tracking++;
            else n_manual++;
            n_accepted <= n_accepted + 1;
        end
    end

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || n_offered == n_accepted) begin
            if (gap_left > 0 && !fast_lane) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (request_queue.size() != 0) begin
                next_req = request_queue.pop_front();
                i_target_angle <= next_req.target;
                i_measured_angle <= next_req.measured;
                i_elapsed_us <= next_req.elapsed;
                i_manual_rate <= next_req.rate;
                i_in_valid <= 1'b1;
                n_offered++;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = int'($urandom_range(0, 24));
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 30));
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: its own stall pattern, plus two long hold-offs that back the
    // block up into its input.
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0) rx_mode = t_stall_pattern'($urandom_range(0, 3));
        if (!i_rst_n || fast_lane) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (holds_done < 2 && n_accepted >= 200 + 450 * holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            case (rx_mode)
                STALL_HALF:     i_out_stall <= 1'($urandom_range(0, 1));
                STALL_MOST:     i_out_stall <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: i_out_stall <= ((rx_cycle % 7) < 3);
                default:        i_out_stall <= 1'b0;
            endcase
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_drive_q.size() == 0) begin
                $error("drive result with no request outstanding");
                fail_count++;
            end else begin
                want_drive = expected_drive_q.pop_front();
                check_field("lead_one_duty", longint'(want_drive.lead_one),
                            longint'(o_lead_one_duty));
                check_field("lead_two_duty", longint'(want_drive.lead_two),
                            longint'(o_lead_two_duty));
                check_field("forward", longint'(want_drive.fwd), longint'(o_forward));
                check_field("pid_value", longint'($signed(want_drive.pid)),
                            longint'(o_pid_value));
            end
        end
    end

    task automatic write_reg(input logic [pmd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pmd_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            pmd_pkg::CFG_KP:    gain_p = val;
            pmd_pkg::CFG_KI:    gain_i = val;
            pmd_pkg::CFG_KD:    gain_d = val;
            pmd_pkg::CFG_TRACK: track_on = val[0];
            pmd_pkg::CFG_ALT:   alt_on = val[0];
            default: ;
        endcase
    endtask

    // Mode bits go out with random upper bits, which the block must ignore.
    task automatic load_gains(input logic [pmd_pkg::GAIN_W-1:0] kp, ki, kd,
                              input bit track, alt);
        logic [pmd_pkg::CFG_DATA_W-2:0] junk;
        junk = (pmd_pkg::CFG_DATA_W-1)'($urandom);
        write_reg(pmd_pkg::CFG_KP, kp);
        write_reg(pmd_pkg::CFG_KI, ki);
        write_reg(pmd_pkg::CFG_KD, kd);
        write_reg(pmd_pkg::CFG_TRACK, {junk, track});
        junk = (pmd_pkg::CFG_DATA_W-1)'($urandom);
        write_reg(pmd_pkg::CFG_ALT, {junk, alt});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (request_queue.size() != 0 || i_in_valid || expected_drive_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void offer_period(input logic [15:0] tgt, meas, el, rate);
        request_queue.push_back({tgt, meas, el, rate});
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [pmd_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 24'h010000;
            3:       return 24'($urandom_range(0, 255));
            4:       return 24'($urandom_range(0, 24'h03FFFF));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_axis_req make_request();
        t_axis_req rq;
        rq.rate = 16'($urandom);
        if ($urandom_range(0, 4) != 0) begin
            // A sensible control period: axis near its target, period of a few ms.
            rq.measured = 16'($urandom);
            rq.target = rq.measured + 16'($urandom_range(0, 4000)) - 16'd2000;
            if (alt_on && $urandom_range(0, 1) == 1) rq.target = 16'($urandom_range(0, 16500));
            rq.elapsed = 16'($urandom_range(2000, 20000));
        end else begin
            rq.target = pick_extreme();
            rq.measured = pick_extreme();
            rq.elapsed = pick_extreme();
        end
        return rq;
    endfunction

    initial begin
        int ph;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Manual drive straight out of reset: sign, zero, extremes and the 255 limit.
        offer_period(16'($urandom), 16'($urandom), 16'($urandom), 16'h0000);
        offer_period(16'($urandom), 16'($urandom), 16'($urandom), 16'h0001);
        offer_period(16'($urandom), 16'($urandom), 16'($urandom), 16'hFFFF);
        offer_period(16'($urandom), 16'($urandom), 16'($urandom), 16'h7FFF);
        offer_period(16'($urandom), 16'($urandom), 16'($urandom), 16'h8000);
        offer_period(16'($urandom), 16'($urandom), 16'($urandom), 16'd1305);
        offer_period(16'($urandom), 16'($urandom), 16'($urandom), -16'sd1306);
        offer_period(16'($urandom), 16'($urandom), 16'($urandom), 16'd2621);
        drain();

        // Tracking: zero period, on target, full-scale errors, half-turn direction.
        load_gains(24'h010000, 24'h000100, 24'h020000, 1'b1, 1'b0);
        offer_period(16'd1000, 16'd900, 16'd0, 16'($urandom));
        offer_period(16'd900, 16'd900, 16'd10000, 16'($urandom));
        offer_period(16'hFFFF, 16'h0000, 16'hFFFF, 16'($urandom));
        offer_period(16'h0000, 16'hFFFF, 16'd1, 16'($urandom));
        offer_period(16'h8000, 16'h0000, 16'd100, 16'($urandom));
        offer_period(16'h8001, 16'h0000, 16'd100, 16'($urandom));
        offer_period(16'h0000, 16'h8000, 16'd100, 16'($urandom));
        offer_period(16'd5, 16'd10, 16'hFFFF, 16'($urandom));
        drain();

        // Altitude axis: zenith at, just past and far past a quarter turn.
        load_gains(24'h008000, 24'h000010, 24'h000000, 1'b1, 1'b1);
        offer_period(16'd0, 16'd100, 16'd1000, 16'($urandom));
        offer_period(16'd16384, 16'd100, 16'd1000, 16'($urandom));
        offer_period(16'd16385, 16'd100, 16'd1000, 16'($urandom));
        offer_period(16'hFFFF, 16'd100, 16'd1000, 16'($urandom));
        offer_period(16'd8000, 16'd100, 16'd1000, 16'($urandom));
        drain();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_gains('1, '1, '1, 1'b1, 1'b0);
                1: load_gains('0, '0, '0, 1'b1, 1'b1);
                default: load_gains(pick_gain(), pick_gain(), pick_gain(),
                                    $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
            endcase
            repeat (125) request_queue.push_back(make_request());
            drain();
        end

        // Drive the integral term into its limit at full rate, then step back off it.
        fast_lane = 1'b1;
        load_gains(24'h000100, '1, pick_gain(), 1'b1, 1'b0);
        repeat (40) offer_period(16'hFFFF, 16'h0000, 16'hFFFF, 16'($urandom));
        repeat (30) offer_period(16'h0000, 16'hFFFF, 16'hFFFF, 16'($urandom));
        repeat (2) offer_period(16'($urandom), 16'($urandom), 16'h0000, 16'($urandom));
        drain();
        fast_lane = 1'b0;

        repeat (40) @(posedge i_clk);
        if (expected_drive_q.size() != 0) begin
            $error("%0d drive results never arrived", expected_drive_q.size());
            fail_count++;
        end
        $display("Checked %0d tracking and %0d manual requests over %0d register settings,",
                 n_tracking, n_manual, n_settings);
        $display("with zenith clamping, half-turn direction, zero periods and the integral cap.");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
